// ===== hdl/md5_pkg.sv =====
// Shared types, constants and round functions of the MD5 hash engine.
package md5_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  localparam logic [WordW-1:0] INIT_A = 32'h67452301;
  localparam logic [WordW-1:0] INIT_B = 32'hefcdab89;
  localparam logic [WordW-1:0] INIT_C = 32'h98badcfe;
  localparam logic [WordW-1:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [2:0] LEN_ROW    = 3'd7;

  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  typedef struct packed {
    logic       absorb;
    logic       pad;
    logic       len_block;
    logic       init;
    logic       round;
    logic       fold;
    logic       fold_final;
    logic [5:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } stat_t;

  function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
    logic [3:0] idx;
    unique case (rnd[5:4])
      2'd0: idx = rnd[3:0];
      2'd1: idx = rnd[3:0] * 4'd5 + 4'd1;
      2'd2: idx = rnd[3:0] * 4'd3 + 4'd5;
      default: idx = rnd[3:0] * 4'd7;
    endcase
    return idx;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [1:0] sel,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    unique case (sel)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [4:0] s);
    logic [2*WordW-1:0] t;
    t = {x, x} << s;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

// ===== hdl/md5_if.sv =====
// Stream interfaces for message items and digest results.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, input ready);
  modport sink (input valid, input digest_word0, input digest_word1,
                input digest_word2, input digest_word3, output ready);
endinterface

// ===== hdl/md5_hash_engine.sv =====
// MD5 hash engine top level: absorbs bytes, pads and emits the digest.
// An absorb transaction writes one byte; the byte that fills a block starts a compression
// (a set-up step, 64 rounds of the shared round unit, then a feed-forward step).
// A finish transaction runs one compression, or two when padding needs a second block;
// the digest register frees the input side while a result waits.
// Reset loads the initial chaining words and clears the block buffer and byte count.
module md5_hash_engine (
  input  logic   clk_i,
  input  logic   rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  md5_pkg::cmd_t  cmd_w;
  md5_pkg::stat_t stat_w;
  logic [31:0]    digest_w [4];

  md5_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat_w),
    .cmd_o       (cmd_w)
  );

  md5_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_w),
    .data_byte_i (in_i.data_byte),
    .stat_o      (stat_w),
    .digest_o    (digest_w)
  );

  assign out_o.digest_word0 = digest_w[0];
  assign out_o.digest_word1 = digest_w[1];
  assign out_o.digest_word2 = digest_w[2];
  assign out_o.digest_word3 = digest_w[3];

  a_block_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.action && stat_w.pos == md5_pkg::LAST_POS)
      |=> !in_i.ready)
    else $error("input taken while a full block awaits compression");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action) |=> !in_i.ready)
    else $error("input taken during finish padding");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> (stat_w.pos == 6'd0))
    else $error("byte count not cleared with digest");

endmodule

// ===== hdl/md5_dp.sv =====
// Datapath: block buffer, byte count, round unit, chaining and digest registers.
module md5_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  md5_pkg::cmd_t       cmd_i,
  input  logic [7:0]          data_byte_i,
  output md5_pkg::stat_t      stat_o,
  output logic [31:0]         digest_o [4]
);

  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] blk_q [16];
  logic [31:0] blk_d [16];
  logic [31:0] digest_q [4];
  logic [63:0] count_q;
  logic [31:0] a_q, b_q, c_q, d_q, pre_q;
  logic [31:0] pre_d, nb_w, sum_w, fold_w [4];
  logic [63:0] bits_w;
  logic [3:0]  wi_w;
  logic [1:0]  lane_w;
  logic [5:0]  rd_sel_w;

  assign wi_w   = count_q[5:2];
  assign lane_w = count_q[1:0];
  assign bits_w = {count_q[60:0], 3'b000};
  assign stat_o.pos = count_q[5:0];

  assign rd_sel_w = cmd_i.init ? 6'd0 : cmd_i.rnd + 6'd1;
  assign pre_d = (cmd_i.init ? chain_q[0] : d_q) + md5_pkg::ROUND_K[rd_sel_w]
                 + blk_q[md5_pkg::msg_idx(rd_sel_w)];
  assign sum_w = pre_q + md5_pkg::round_f(cmd_i.rnd[5:4], b_q, c_q, d_q);
  assign nb_w  = b_q + md5_pkg::rotl(sum_w, md5_pkg::ROT_S[cmd_i.rnd[5:4]][cmd_i.rnd[1:0]]);

  assign fold_w[0] = chain_q[0] + a_q;
  assign fold_w[1] = chain_q[1] + b_q;
  assign fold_w[2] = chain_q[2] + c_q;
  assign fold_w[3] = chain_q[3] + d_q;

  always_comb begin
    blk_d = blk_q;
    priority if (cmd_i.fold_final) begin
      for (int k = 0; k < 16; k++) blk_d[k] = '0;
    end else if (cmd_i.len_block) begin
      for (int k = 0; k < 16; k++) blk_d[k] = '0;
      blk_d[14] = bits_w[31:0];
      blk_d[15] = bits_w[63:32];
    end else if (cmd_i.pad) begin
      for (int k = 0; k < 16; k++) begin
        if (4'(k) > wi_w) begin
          blk_d[k] = '0;
        end else if (4'(k) == wi_w) begin
          for (int j = 0; j < 4; j++) begin
            if (2'(j) == lane_w) begin
              blk_d[k][j*8 +: 8] = md5_pkg::PAD_MARKER;
            end else if (2'(j) > lane_w) begin
              blk_d[k][j*8 +: 8] = '0;
            end
          end
        end
      end
      if (count_q[5:3] != md5_pkg::LEN_ROW) begin
        blk_d[14] = bits_w[31:0];
        blk_d[15] = bits_w[63:32];
      end
    end else if (cmd_i.absorb) begin
      for (int j = 0; j < 4; j++) begin
        if (2'(j) == lane_w) blk_d[wi_w][j*8 +: 8] = data_byte_i;
      end
    end else begin
      blk_d = blk_q;
    end
  end

  always_comb begin
    chain_d = chain_q;
    priority if (cmd_i.fold_final) begin
      chain_d[0] = md5_pkg::INIT_A;
      chain_d[1] = md5_pkg::INIT_B;
      chain_d[2] = md5_pkg::INIT_C;
      chain_d[3] = md5_pkg::INIT_D;
    end else if (cmd_i.fold) begin
      chain_d = fold_w;
    end else begin
      chain_d = chain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= md5_pkg::INIT_A;
      chain_q[1] <= md5_pkg::INIT_B;
      chain_q[2] <= md5_pkg::INIT_C;
      chain_q[3] <= md5_pkg::INIT_D;
      count_q    <= '0;
      for (int k = 0; k < 16; k++) blk_q[k] <= '0;
    end else begin
      chain_q <= chain_d;
      blk_q   <= blk_d;
      if (cmd_i.fold_final) begin
        count_q <= '0;
      end else if (cmd_i.absorb) begin
        count_q <= count_q + 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      a_q   <= chain_q[0];
      b_q   <= chain_q[1];
      c_q   <= chain_q[2];
      d_q   <= chain_q[3];
      pre_q <= pre_d;
    end else if (cmd_i.round) begin
      a_q   <= d_q;
      b_q   <= nb_w;
      c_q   <= b_q;
      d_q   <= c_q;
      pre_q <= pre_d;
    end
    if (cmd_i.fold_final) digest_q <= fold_w;
  end

  assign digest_o = digest_q;

endmodule

// ===== hdl/md5_ctrl.sv =====
// Controller: sequences absorb, padding, 64 rounds and digest hand-off.
module md5_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_action_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  md5_pkg::stat_t stat_i,
  output md5_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_ROUND,
    S_FOLD
  } state_e;

  state_e     state_q;
  logic [5:0] rnd_q;
  logic       final_q;
  logic       two_q;
  logic       out_valid_q;
  logic       accept_w;
  logic       stall_w;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept_w    = in_valid_i && in_ready_o;
  assign stall_w     = out_valid_q && !out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.rnd        = rnd_q;
    cmd_o.absorb     = accept_w && !in_action_i;
    cmd_o.pad        = accept_w && in_action_i;
    cmd_o.init       = (state_q == S_INIT);
    cmd_o.round      = (state_q == S_ROUND);
    cmd_o.fold       = (state_q == S_FOLD) && !final_q;
    cmd_o.len_block  = (state_q == S_FOLD) && !final_q && two_q;
    cmd_o.fold_final = (state_q == S_FOLD) && final_q && !stall_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      final_q     <= 1'b0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.fold_final) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept_w) begin
            if (in_action_i) begin
              final_q <= (stat_i.pos[5:3] != md5_pkg::LEN_ROW);
              two_q   <= (stat_i.pos[5:3] == md5_pkg::LEN_ROW);
              state_q <= S_INIT;
            end else if (stat_i.pos == md5_pkg::LAST_POS) begin
              final_q <= 1'b0;
              two_q   <= 1'b0;
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          rnd_q   <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == md5_pkg::LAST_POS) state_q <= S_FOLD;
        end
        S_FOLD: begin
          priority if (final_q) begin
            if (!stall_w) begin
              final_q     <= 1'b0;
              state_q     <= S_IDLE;
            end
          end else if (two_q) begin
            two_q   <= 1'b0;
            final_q <= 1'b1;
            state_q <= S_INIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/md5_hash_engine_tb.sv =====
// Self-checking testbench of the MD5 hash engine: random messages against a digest model.
module md5_hash_engine_tb;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned ROT_AMOUNT [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  typedef logic [3:0][31:0] digest_t;

  class md5_digest_model;
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [63:0] msg_bytes;
    digest_t     pending_digests [$];
    int unsigned errors;
    int unsigned digests_compared;
    int unsigned messages_hashed;
    int unsigned bytes_hashed;

    function new();
      restart();
    endfunction

    function void restart();
      chain[0] = md5_pkg::INIT_A;
      chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C;
      chain[3] = md5_pkg::INIT_D;
      foreach (blk[k]) blk[k] = '0;
      msg_bytes = '0;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, sum;
      int unsigned w, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int unsigned r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            w = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            w = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            w = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            w = (7 * r) % 16;
          end
        endcase
        sum = a + f + SINE_K[r] + blk[w];
        s = ROT_AMOUNT[r / 16][r % 4];
        a = d;
        d = c;
        c = b;
        b = b + ((sum << s) | (sum >> (32 - s)));
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void take_item(input logic act, input logic [7:0] data);
      logic [5:0]  pos;
      logic [63:0] bits;
      int unsigned wi, lane;
      digest_t     dg;
      pos  = msg_bytes[5:0];
      wi   = pos[5:2];
      lane = pos[1:0];
      if (act == ACT_ABSORB) begin
        blk[wi][lane*8 +: 8] = data;
        msg_bytes++;
        bytes_hashed++;
        if (pos == 6'd63) compress();
      end else begin
        bits = msg_bytes << 3;
        blk[wi][lane*8 +: 8] = 8'h80;
        for (int unsigned k = lane + 1; k < 4; k++) blk[wi][k*8 +: 8] = 8'h00;
        for (int unsigned k = wi + 1; k < 16; k++) blk[k] = '0;
        if (pos >= 6'd56) begin
          compress();
          foreach (blk[k]) blk[k] = '0;
        end
        blk[14] = bits[31:0];
        blk[15] = bits[63:32];
        compress();
        for (int k = 0; k < 4; k++) dg[k] = chain[k];
        pending_digests.push_back(dg);
        messages_hashed++;
        restart();
      end
    endfunction

    function void compare_digest(input digest_t got);
      digest_t want;
      if (pending_digests.size() == 0) begin
        $error("digest %h arrived with no message finished", got);
        errors++;
        return;
      end
      want = pending_digests.pop_front();
      digests_compared++;
      for (int k = 0; k < 4; k++) begin
        if (got[k] !== want[k]) begin
          $error("digest_word%0d: expected %h, actual %h", k, want[k], got[k]);
          errors++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_digests.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;
  int unsigned items_sent = 0;

  md5_digest_model digest_model = new();

  md5_in_if  in_bus ();
  md5_out_if out_bus ();

  md5_hash_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    digest_t got;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.digest_word3, out_bus.digest_word2,
               out_bus.digest_word1, out_bus.digest_word0};
        digest_model.compare_digest(got);
      end
      out_bus.ready <= rst_ni && (calm || $urandom_range(99) >= 23);
    end
  end

  task automatic send_item(input logic act, input logic [7:0] data);
    while (!calm && $urandom_range(99) < 23) begin
      in_bus.valid     <= 1'b0;
      in_bus.action    <= 1'($urandom);
      in_bus.data_byte <= 8'($urandom);
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.data_byte <= data;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    digest_model.take_item(act, data);
    items_sent++;
    calm = (items_sent >= 400 && items_sent < 650);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_model.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(ACT_ABSORB, 8'($urandom));
    send_item(ACT_FINISH, 8'($urandom));
  endtask

  initial begin
    int unsigned boundary_lens [10];
    int unsigned len, pick;
    int unsigned msg_no;
    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    in_bus.valid     <= 1'b0;
    in_bus.action    <= ACT_ABSORB;
    in_bus.data_byte <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_ABSORB, 8'h61);
    send_item(ACT_ABSORB, 8'h62);
    send_item(ACT_ABSORB, 8'h63);
    send_item(ACT_FINISH, 8'hff);
    send_item(ACT_ABSORB, 8'h00);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_ABSORB, 8'hff);
    send_item(ACT_FINISH, 8'h5a);
    send_item(ACT_FINISH, 8'ha5);
    drain();

    msg_no = 0;
    while (items_sent < 1000) begin
      pick = $urandom_range(99);
      if (pick < 15) len = boundary_lens[$urandom_range(9)];
      else if (pick < 90) len = $urandom_range(24);
      else len = $urandom_range(130, 41);
      send_message(len);
      msg_no++;
      if (msg_no == 12) drain();
    end

    drain();
    repeat (150) @(posedge clk_i);
    $display("Hashed %0d messages totalling %0d bytes, including padding boundary lengths",
             digest_model.messages_hashed, digest_model.bytes_hashed);
    $display("Compared %0d digests with random idling on both sides",
             digest_model.digests_compared);
    if (digest_model.errors == 0 && digest_model.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
